// ----- src/ezr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared constants, types and tables of the Euler rotation matrix core.
// ----------------------------------------------------------------------------
package ezr_pkg;

   localparam int TBL_LEN           = 24;
   localparam int DEF_CORDIC_STEPS  = 16;
   localparam int DEF_OUT_FRAC_BITS = 14;
   localparam int ANGLE_W           = 16;
   localparam int OUT_W             = 16;
   localparam int Q_W               = 34;   // Q30 signed values in [-8, 8)
   localparam int NUM_OUT           = 9;

   localparam logic signed [Q_W-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [Q_W-1:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [Q_W-1:0] Q30_GAIN    = 34'sd652032874;

   typedef logic signed [Q_W-1:0] q30_type;

   // CORDIC working set carried from one step to the next
   typedef struct packed {
      q30_type x;
      q30_type y;
      q30_type z;
      logic    neg;
   } cordic_type;

   function automatic q30_type atan_q30(input int i);
      q30_type r;
      r = '0;
      case (i)
         0:  r = 34'sd843314856;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043836;
         3:  r = 34'sd133525158;
         4:  r = 34'sd67021686;
         5:  r = 34'sd33543515;
         6:  r = 34'sd16775850;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194282;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048575;
         11: r = 34'sd524287;
         12: r = 34'sd262143;
         13: r = 34'sd131071;
         14: r = 34'sd65535;
         15: r = 34'sd32767;
         16: r = 34'sd16383;
         17: r = 34'sd8191;
         18: r = 34'sd4095;
         19: r = 34'sd2047;
         20: r = 34'sd1023;
         21: r = 34'sd511;
         22: r = 34'sd255;
         23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q30 x Q30 product rounded back to Q30
   function automatic q30_type mul30(input q30_type a, input q30_type b);
      logic signed [2*Q_W-1:0] p;
      p = a * b + (68'sd1 <<< 29);
      return q30_type'(p >>> 30);
   endfunction

endpackage

// ----- src/ezr_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezr_cordic
// Pipelined rotation-mode CORDIC: one register stage per step, plus a
// folding stage in front. Stalls hold every stage.
// ----------------------------------------------------------------------------
module ezr_cordic #(
   parameter int CORDIC_STEPS = ezr_pkg::DEF_CORDIC_STEPS
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [ezr_pkg::ANGLE_W-1:0] angle,
   output ezr_pkg::q30_type            sin_q,
   output ezr_pkg::q30_type            cos_q
);
   localparam int NST = (CORDIC_STEPS > ezr_pkg::TBL_LEN) ? ezr_pkg::TBL_LEN
                                                         : CORDIC_STEPS;

   ezr_pkg::cordic_type st_ff [NST+1];
   ezr_pkg::cordic_type fold_in;
   ezr_pkg::q30_type    z0;

   always_comb begin
      z0 = ezr_pkg::q30_type'(angle) <<< 17;
      fold_in.x   = ezr_pkg::Q30_GAIN;
      fold_in.y   = '0;
      fold_in.z   = z0;
      fold_in.neg = 1'b0;
      if (z0 > ezr_pkg::Q30_HALF_PI) begin
         fold_in.z   = z0 - ezr_pkg::Q30_PI;
         fold_in.neg = 1'b1;
      end else if (z0 < -ezr_pkg::Q30_HALF_PI) begin
         fold_in.z   = z0 + ezr_pkg::Q30_PI;
         fold_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) st_ff[0] <= fold_in;
   end

   for (genvar i = 0; i < NST; i++) begin : g_step
      ezr_pkg::cordic_type step_in;
      always_comb begin
         step_in = st_ff[i];
         if (!st_ff[i].z[ezr_pkg::Q_W-1]) begin
            step_in.x = st_ff[i].x - (st_ff[i].y >>> i);
            step_in.y = st_ff[i].y + (st_ff[i].x >>> i);
            step_in.z = st_ff[i].z - ezr_pkg::atan_q30(i);
         end else begin
            step_in.x = st_ff[i].x + (st_ff[i].y >>> i);
            step_in.y = st_ff[i].y - (st_ff[i].x >>> i);
            step_in.z = st_ff[i].z + ezr_pkg::atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         if (enable) st_ff[i+1] <= step_in;
      end
   end

   // undo the fold
   assign sin_q = st_ff[NST].neg ? -st_ff[NST].y : st_ff[NST].y;
   assign cos_q = st_ff[NST].neg ? -st_ff[NST].x : st_ff[NST].x;

endmodule

// ----- src/euler_xyz_rotation_matrix_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix_core
// Euler angles (x, y, z) to rotation matrix R = Rx*Ry*Rz.
// ----------------------------------------------------------------------------
// The core takes one angle triple per cycle and returns one matrix per cycle while rsp_tready stays high.
// The pipe is one fold stage and one stage per CORDIC step (24 max steps)
// for the three sine/cosine units running side by side, then three product
// stages (sa*sb and ca*sb; the two-factor terms; the sums) and one output
// register that rounds and saturates. The whole pipe advances only when its
// last stage is empty or being taken, so a stall on the result side holds
// every item in place; throughput is one transfer per cycle while rsp_tready
// stays high.
module euler_xyz_rotation_matrix_core #(
   parameter int CORDIC_STEPS  = ezr_pkg::DEF_CORDIC_STEPS,
   parameter int OUT_FRAC_BITS = ezr_pkg::DEF_OUT_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // angle_x, angle_y, angle_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);
   localparam int NST = (CORDIC_STEPS > ezr_pkg::TBL_LEN) ? ezr_pkg::TBL_LEN
                                                         : CORDIC_STEPS;
   localparam int LAT = NST + 5;
   localparam int SH  = 30 - OUT_FRAC_BITS;

   typedef ezr_pkg::q30_type q_type;

   logic           adv;
   logic [LAT-1:0] vld_ff;
   q_type          sa, ca, sb, cb, sg, cg;

   // advance when the output slot frees up
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   ezr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cx (
      .clock(clock), .enable(adv), .angle(req_tdata[15:0]),
      .sin_q(sa), .cos_q(ca));
   ezr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cy (
      .clock(clock), .enable(adv), .angle(req_tdata[31:16]),
      .sin_q(sb), .cos_q(cb));
   ezr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cz (
      .clock(clock), .enable(adv), .angle(req_tdata[47:32]),
      .sin_q(sg), .cos_q(cg));

   // stage A: hold trig values and form sa*sb, ca*sb
   q_type sa_ff, ca_ff, sb_ff, cb_ff, sg_ff, cg_ff, sasb_ff, casb_ff;
   // stage B: two-factor terms
   q_type t00_ff, t01_ff, t02_ff, t10a_ff, t10b_ff, t11a_ff, t11b_ff;
   q_type t12_ff, t20a_ff, t20b_ff, t21a_ff, t21b_ff, t22_ff;
   // stage C: sums
   q_type s_ff [ezr_pkg::NUM_OUT];
   logic [ezr_pkg::OUT_W-1:0] o_ff [ezr_pkg::NUM_OUT];

   function automatic logic [ezr_pkg::OUT_W-1:0] to_out(input q_type v);
      logic signed [ezr_pkg::Q_W:0] r;
      logic signed [ezr_pkg::Q_W:0] lim;
      lim = (ezr_pkg::Q_W+1)'(1) <<< OUT_FRAC_BITS;
      if (SH == 0) r = (ezr_pkg::Q_W+1)'(v);
      else r = ((ezr_pkg::Q_W+1)'(v) + ((ezr_pkg::Q_W+1)'(1) <<< (SH-1))) >>> SH;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[ezr_pkg::OUT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff <= sa; ca_ff <= ca; sb_ff <= sb;
         cb_ff <= cb; sg_ff <= sg; cg_ff <= cg;
         sasb_ff <= ezr_pkg::mul30(sa, sb);
         casb_ff <= ezr_pkg::mul30(ca, sb);

         t00_ff  <= ezr_pkg::mul30(cb_ff, cg_ff);
         t01_ff  <= -ezr_pkg::mul30(cb_ff, sg_ff);
         t02_ff  <= sb_ff;
         t10a_ff <= ezr_pkg::mul30(sasb_ff, cg_ff);
         t10b_ff <= ezr_pkg::mul30(ca_ff, sg_ff);
         t11a_ff <= ezr_pkg::mul30(ca_ff, cg_ff);
         t11b_ff <= ezr_pkg::mul30(sasb_ff, sg_ff);
         t12_ff  <= -ezr_pkg::mul30(sa_ff, cb_ff);
         t20a_ff <= ezr_pkg::mul30(sa_ff, sg_ff);
         t20b_ff <= ezr_pkg::mul30(casb_ff, cg_ff);
         t21a_ff <= ezr_pkg::mul30(casb_ff, sg_ff);
         t21b_ff <= ezr_pkg::mul30(sa_ff, cg_ff);
         t22_ff  <= ezr_pkg::mul30(ca_ff, cb_ff);

         s_ff[0] <= t00_ff;
         s_ff[1] <= t01_ff;
         s_ff[2] <= t02_ff;
         s_ff[3] <= t10a_ff + t10b_ff;
         s_ff[4] <= t11a_ff - t11b_ff;
         s_ff[5] <= t12_ff;
         s_ff[6] <= t20a_ff - t20b_ff;
         s_ff[7] <= t21a_ff + t21b_ff;
         s_ff[8] <= t22_ff;

         for (int k = 0; k < ezr_pkg::NUM_OUT; k++) o_ff[k] <= to_out(s_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < ezr_pkg::NUM_OUT; k++) begin
         rsp_tdata[k*ezr_pkg::OUT_W +: ezr_pkg::OUT_W] = o_ff[k];
      end
   end

endmodule
